### src/modexp_pkg.sv
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared types and constants of the modular exponentiation block: register
// indexes, multiplier operand selects, and controller/datapath interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package modexp_pkg;

  // default operand width
  localparam int WIDTH_DEF = 32;

  // configuration register index
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_EXP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIVATE_EXP  = 2'd2;

  // operand pair handed to the modular multiplier
  typedef enum logic [1:0] {
    MSEL_REDUCE = 2'd0,  // 1 * base: reduces the base
    MSEL_MULT   = 2'd1,  // acc * running base
    MSEL_SQUARE = 2'd2   // running base * running base
  } msel_t;

  // controller -> datapath
  typedef struct packed {
    logic  load;       // capture input word and selected exponent
    logic  mul_start;  // launch modular multiply
    msel_t mul_sel;
    logic  wb_base;    // multiplier result -> running base
    logic  wb_acc;     // multiplier result -> accumulator
    logic  shift_e;    // drop exponent low bit
    logic  res_load;   // accumulator -> output register
  } me_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic m_zero;
    logic e_zero;
    logic e_hi_zero;
    logic e_lsb;
    logic mm_busy;
    logic mm_done;
  } me_stat_t;

endpackage

`default_nettype wire

### src/modexp_mulmod.sv
// ----------------------------------------------------------------------------
// modexp_mulmod
// Bit-serial modular multiplier: (a * b) mod m, scanning b from its top bit,
// one double-and-add step with reduction per cycle, WIDTH steps per product.
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_mulmod #(
  parameter int WIDTH = modexp_pkg::WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] op_a,     // a < m, or a == 1
  input  wire logic [WIDTH-1:0] op_b,
  input  wire logic [WIDTH-1:0] modulus,
  output logic                  busy,
  output logic                  done,     // one-cycle pulse, result valid
  output logic      [WIDTH-1:0] result
);

  import modexp_pkg::*;

  localparam int CW = $clog2(WIDTH);
  localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] a_r;
  logic [WIDTH-1:0] b_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [WIDTH+1:0] sum;
  logic [WIDTH+1:0] m1;
  logic [WIDTH+1:0] m2;

  // 2*acc + bit*a stays below 3m; subtract m or 2m as needed
  always_comb begin
    m1  = {2'b00, modulus};
    m2  = {1'b0, modulus, 1'b0};
    sum = {1'b0, acc_r, 1'b0} + (b_r[WIDTH-1] ? {2'b00, a_r} : '0);
    if (sum >= m2) begin
      acc_nxt = WIDTH'(sum - m2);
    end else if (sum >= m1) begin
      acc_nxt = WIDTH'(sum - m1);
    end else begin
      acc_nxt = WIDTH'(sum);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= op_a;
      b_r   <= op_b;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[WIDTH-2:0], 1'b0};
    end
  end

  assign busy   = busy_r;
  assign done   = done_r;
  assign result = acc_r;

endmodule

`default_nettype wire

### src/modexp_dp.sv
// ----------------------------------------------------------------------------
// modexp_dp
// Datapath: configuration registers, exponent shifter, running base,
// accumulator, output register and the shared modular multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_dp #(
  parameter int WIDTH = modexp_pkg::WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [modexp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [WIDTH-1:0]                    cfg_data,
  input  wire logic                                in_mode,
  input  wire logic [WIDTH-1:0]                    in_base,
  input  wire modexp_pkg::me_cmd_t                 cmd,
  output modexp_pkg::me_stat_t                     stat,
  output logic      [WIDTH-1:0]                    out_power_result
);

  import modexp_pkg::*;

  logic [WIDTH-1:0] modulus_r;
  logic [WIDTH-1:0] pub_exp_r;
  logic [WIDTH-1:0] priv_exp_r;
  logic [WIDTH-1:0] base_r;
  logic [WIDTH-1:0] bv_r;
  logic [WIDTH-1:0] acc_r;
  logic [WIDTH-1:0] e_r;
  logic [WIDTH-1:0] res_r;

  logic [WIDTH-1:0] exp_sel;
  logic [WIDTH-1:0] acc_init;
  logic [WIDTH-1:0] op_a;
  logic [WIDTH-1:0] op_b;
  logic             mm_busy;
  logic             mm_done;
  logic [WIDTH-1:0] mm_result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= WIDTH'(1);
      pub_exp_r  <= WIDTH'(1);
      priv_exp_r <= WIDTH'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODULUS:     modulus_r  <= cfg_data;
        CFG_PUBLIC_EXP:  pub_exp_r  <= cfg_data;
        CFG_PRIVATE_EXP: priv_exp_r <= cfg_data;
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // exponent select and accumulator start value
  // zero modulus gives 0, zero exponent gives 1 unreduced, else 1 mod m
  always_comb begin
    exp_sel = in_mode ? priv_exp_r : pub_exp_r;
    if (modulus_r == '0) begin
      acc_init = '0;
    end else if (exp_sel == '0) begin
      acc_init = WIDTH'(1);
    end else if (modulus_r == WIDTH'(1)) begin
      acc_init = '0;
    end else begin
      acc_init = WIDTH'(1);
    end
  end

  // multiplier operand mux
  always_comb begin
    case (cmd.mul_sel)
      MSEL_REDUCE: begin
        op_a = WIDTH'(1);
        op_b = base_r;
      end
      MSEL_MULT: begin
        op_a = acc_r;
        op_b = bv_r;
      end
      MSEL_SQUARE: begin
        op_a = bv_r;
        op_b = bv_r;
      end
      default: begin
        op_a = bv_r;
        op_b = bv_r;
      end
    endcase
  end

  modexp_mulmod #(
    .WIDTH (WIDTH)
  ) u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.mul_start),
    .op_a    (op_a),
    .op_b    (op_b),
    .modulus (modulus_r),
    .busy    (mm_busy),
    .done    (mm_done),
    .result  (mm_result)
  );

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r <= in_base;
      e_r    <= exp_sel;
    end else if (cmd.shift_e) begin
      e_r <= {1'b0, e_r[WIDTH-1:1]};
    end

    if (cmd.load) begin
      acc_r <= acc_init;
    end else if (cmd.wb_acc) begin
      acc_r <= mm_result;
    end

    if (cmd.wb_base) begin
      bv_r <= mm_result;
    end

    if (cmd.res_load) begin
      res_r <= acc_r;
    end
  end

  // status
  always_comb begin
    stat.m_zero    = (modulus_r == '0);
    stat.e_zero    = (e_r == '0);
    stat.e_hi_zero = (e_r[WIDTH-1:1] == '0);
    stat.e_lsb     = e_r[0];
    stat.mm_busy   = mm_busy;
    stat.mm_done   = mm_done;
  end

  assign out_power_result = res_r;

endmodule

`default_nettype wire

### src/modexp_ctrl.sv
// ----------------------------------------------------------------------------
// modexp_ctrl
// Controller: sequences base reduction and the square-and-multiply scan,
// and owns the input ready and output valid handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output modexp_pkg::me_cmd_t       cmd,
  input  wire modexp_pkg::me_stat_t stat
);

  import modexp_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CHECK  = 7'b0000010,
    S_RED    = 7'b0000100,
    S_STEP   = 7'b0001000,
    S_MUL    = 7'b0010000,
    S_SQR    = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MSEL_REDUCE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.m_zero || stat.e_zero) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MSEL_REDUCE;
          state_nxt     = S_RED;
        end
      end
      S_RED: begin
        if (stat.mm_done) begin
          cmd.wb_base = 1'b1;
          state_nxt   = S_STEP;
        end
      end
      S_STEP: begin
        if (stat.e_zero) begin
          state_nxt = S_FINISH;
        end else if (stat.e_lsb) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MSEL_MULT;
          state_nxt     = S_MUL;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MSEL_SQUARE;
          state_nxt     = S_SQR;
        end
      end
      S_MUL: begin
        if (stat.mm_done) begin
          cmd.wb_acc = 1'b1;
          if (stat.e_hi_zero) begin
            // last exponent bit: the final square is not needed
            cmd.shift_e = 1'b1;
            state_nxt   = S_STEP;
          end else begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MSEL_SQUARE;
            state_nxt     = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (stat.mm_done) begin
          cmd.wb_base = 1'b1;
          cmd.shift_e = 1'b1;
          state_nxt   = S_STEP;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // checks
  a_start_idle_mm: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_start |-> !stat.mm_busy)
    else $error("multiply launched while multiplier busy");

  a_res_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> slot_free)
    else $error("result overwrote an untaken word");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stat.mm_done |-> (state_r == S_RED || state_r == S_MUL || state_r == S_SQR))
    else $error("multiplier done outside a wait state");

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_CHECK))
    else $error("accepted word not followed by check");

endmodule

`default_nettype wire

### src/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// base ** exponent mod modulus by right-to-left square-and-multiply; mode
// picks the public or private exponent from the configuration registers.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  -------  ---------------------  ---------------------------------------
//  in       in_valid / in_ready    in_mode, in_base[WIDTH-1:0]
//  out      out_valid / out_ready  out_power_result[WIDTH-1:0]
//  cfg      cfg_we                 cfg_index[1:0], cfg_data[WIDTH-1:0]
//
//  One word at a time. Each modular product runs in the one shared
//  bit-serial multiplier; an item needs L + k products for an exponent of
//  bit length L with k set bits: one base reduction, L - 1 squares and k
//  multiplies.
//  Zero exponent or zero modulus: done with no modular product.
//  Reset is synchronous, active low; it sets all three registers to 1.
//  A waiting result is held in the output register while the next word is
//  taken; a finished word waits in the accumulator until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation #(
  parameter int WIDTH = modexp_pkg::WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [modexp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WIDTH-1:0]                 cfg_data,
  // input words
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_mode,
  input  wire logic [WIDTH-1:0]                 in_base,
  // result words
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [WIDTH-1:0]                 out_power_result
);

  import modexp_pkg::*;

  me_cmd_t  cmd;
  me_stat_t stat;

  modexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  modexp_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_mode          (in_mode),
    .in_base          (in_base),
    .cmd              (cmd),
    .stat             (stat),
    .out_power_result (out_power_result)
  );

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: modular exponentiation testbench
// Sends base/mode words through the block under a series of key settings and
// checks every result word against a square-and-multiply predictor that runs
// at double width. Both handshakes idle at random outside the last phase. One long receiver hold-off
// backs up the block until it stalls its input.
// ----------------------------------------------------------------------------

module tb;

  import modexp_pkg::*;

  localparam int WIDTH = WIDTH_DEF;
  localparam logic [WIDTH-1:0] ALL_ONES = {WIDTH{1'b1}};
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int LONG_HOLD = 400;
  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_PHASES = 8;
  localparam int WORDS_PER_PHASE = 34;

  typedef struct packed {
    logic             mode;
    logic [WIDTH-1:0] base;
  } exp_req_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WIDTH-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_mode = 1'b0;
  logic [WIDTH-1:0]     in_base = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [WIDTH-1:0]     out_power_result;

  // key copy used for prediction
  logic [WIDTH-1:0] key_modulus = 1;
  logic [WIDTH-1:0] key_public = 1;
  logic [WIDTH-1:0] key_private = 1;

  exp_req_t         pending_reqs[$];
  logic [WIDTH-1:0] expected_powers[$];
  int               words_queued = 0;
  int               words_returned = 0;
  int               error_count = 0;
  logic [WIDTH-1:0] want_power;

  logic quiet_tail = 1'b0;
  logic long_hold_req = 1'b0;
  logic long_hold_done = 1'b0;
  int   hold_left = 0;
  int   stall_left = 0;
  int   gap_left = 0;
  int   idle_cycles = 0;

  modular_exponentiation #(.WIDTH(WIDTH)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_base          (in_base),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_power_result (out_power_result)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // right-to-left square-and-multiply, products held at double width
  function automatic logic [WIDTH-1:0] power_mod(input logic [WIDTH-1:0] b,
                                                 input logic [WIDTH-1:0] e,
                                                 input logic [WIDTH-1:0] m);
    logic [2*WIDTH-1:0] acc;
    logic [2*WIDTH-1:0] run;
    logic [WIDTH-1:0]   exp_left;
    if (m == 0) return '0;
    if (e == 0) return 1;
    run = b % m;
    acc = 1 % m;
    exp_left = e;
    while (exp_left != 0) begin
      if (exp_left[0]) acc = (acc * run) % m;
      run = (run * run) % m;
      exp_left = exp_left >> 1;
    end
    return acc[WIDTH-1:0];
  endfunction

  function automatic logic [WIDTH-1:0] pick_modulus();
    logic [WIDTH-1:0] m;
    case ($urandom_range(0, 9))
      0: m = 1;
      1: m = 2;
      2: m = ALL_ONES;
      3: m = $urandom_range(2, 1000);
      default: m = $urandom;
    endcase
    if (m == 0) m = 1;
    return m;
  endfunction

  // zero, all ones, short or random-length exponents
  function automatic logic [WIDTH-1:0] pick_exponent();
    logic [WIDTH-1:0] e;
    int               len;
    case ($urandom_range(0, 9))
      0: e = '0;
      1: e = ALL_ONES;
      2, 3, 4: e = $urandom_range(1, 255);
      default: begin
        len = $urandom_range(1, WIDTH);
        e = $urandom & (ALL_ONES >> (WIDTH - len));
        e[len-1] = 1'b1;
      end
    endcase
    return e;
  endfunction

  function automatic logic [WIDTH-1:0] pick_base();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ALL_ONES;
      2: return key_modulus - 1;
      3: return key_modulus;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_word(input logic mode, input logic [WIDTH-1:0] base);
    pending_reqs.push_back('{mode: mode, base: base});
    words_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIDTH-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_MODULUS:     key_modulus = value;
      CFG_PUBLIC_EXP:  key_public = value;
      CFG_PRIVATE_EXP: key_private = value;
      default: ;
    endcase
  endtask

  // block is idle once every queued word has come back
  task automatic wait_drained();
    do @(posedge clk); while (words_returned != words_queued);
    repeat (4) @(posedge clk);
  endtask

  // stimulus sequence
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset keys: modulus one, both exponents one
    queue_word(1'b0, '0);
    queue_word(1'b0, 5);
    queue_word(1'b1, ALL_ONES);
    wait_drained();

    // modulus one: zero exponent still gives 1, nonzero gives 0; long hold-off
    write_reg(CFG_MODULUS, 1);
    write_reg(CFG_PUBLIC_EXP, '0);
    write_reg(CFG_PRIVATE_EXP, 5);
    long_hold_req <= 1'b1;
    for (int i = 0; i < 8; i++) queue_word(i[0], i * 7);
    wait_drained();

    // widest key, then a write to the spare index which must change nothing
    write_reg(CFG_MODULUS, ALL_ONES);
    write_reg(CFG_PUBLIC_EXP, ALL_ONES);
    write_reg(CFG_PRIVATE_EXP, '0);
    write_reg(CFG_SPARE, 32'h0000_0003);
    queue_word(1'b0, '0);
    queue_word(1'b0, ALL_ONES);
    queue_word(1'b0, 2);
    queue_word(1'b1, 12345);
    queue_word(1'b0, 32'h8000_0000);
    queue_word(1'b0, ALL_ONES - 1);
    wait_drained();

    // textbook key pair, bases below and above the modulus
    write_reg(CFG_MODULUS, 3233);
    write_reg(CFG_PUBLIC_EXP, 17);
    write_reg(CFG_PRIVATE_EXP, 2753);
    queue_word(1'b0, 65);
    queue_word(1'b1, 2790);
    queue_word(1'b0, 3233 + 65);
    queue_word(1'b1, ALL_ONES);
    wait_drained();

    // random keys and words; the last phase runs without idling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES - 1) quiet_tail <= 1'b1;
      write_reg(CFG_MODULUS, pick_modulus());
      write_reg(CFG_PUBLIC_EXP, pick_exponent());
      write_reg(CFG_PRIVATE_EXP, pick_exponent());
      for (int i = 0; i < WORDS_PER_PHASE; i++) queue_word($urandom_range(0, 1), pick_base());
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // input driver: predicts on acceptance, then offers the next word or idles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_powers.push_back(power_mod(in_base, in_mode ? key_private : key_public,
                                            key_modulus));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
          gap_left <= $urandom_range(0, 10);
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_valid <= 1'b1;
          in_mode  <= pending_reqs[0].mode;
          in_base  <= pending_reqs[0].base;
          void'(pending_reqs.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      words_returned <= words_returned + 1;
      if (expected_powers.size() == 0) begin
        $error("power_result: unexpected word %0h", out_power_result);
        error_count <= error_count + 1;
      end else begin
        want_power = expected_powers.pop_front();
        if (out_power_result !== want_power) begin
          $error("power_result: expected %0h, got %0h", want_power, out_power_result);
          error_count <= error_count + 1;
        end
      end
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      hold_left      <= LONG_HOLD;
      long_hold_done <= 1'b1;
      out_ready      <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
